FILE: hdl/wss_pkg.sv
package wss_pkg;

  localparam int MAX_SOURCES = 16;
  localparam int WEIGHT_BITS = 24;
  localparam int IDX_W       = $clog2(MAX_SOURCES);
  localparam int CNT_W       = $clog2(MAX_SOURCES + 1);
  localparam int FUNC_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int FRAC_W      = 32;
  localparam int SUM_W       = WEIGHT_BITS + IDX_W;
  localparam int PROD_W      = FRAC_W + SUM_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 3'd0,
    FUNC_DELETE = 3'd1,
    FUNC_SET    = 3'd2,
    FUNC_CHOOSE = 3'd3,
    FUNC_CLEAR  = 3'd4,
    FUNC_SAMPLE = 3'd5
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_MUL,
    S_SCAN,
    S_DEL,
    S_RESP
  } state_t;

  typedef struct packed {
    logic clr;
    logic add_total;
    logic mul;
    logic add_cum;
  } scan_ctrl_t;

endpackage

FILE: hdl/wss_if.sv
interface wss_in_if;
  import wss_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [FUNC_W-1:0]      func;
  logic [IDX_W-1:0]       entry_index;
  logic [WEIGHT_BITS-1:0] weight;
  logic [FRAC_W-1:0]      rand_fraction;

  modport source (output valid, func, entry_index, weight, rand_fraction, input ready);
  modport sink   (input valid, func, entry_index, weight, rand_fraction, output ready);
endinterface

interface wss_out_if;
  import wss_pkg::*;
  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    selected_index;
  logic [CNT_W-1:0]    entry_count;
  logic [STATUS_W-1:0] status;

  modport source (output valid, selected_index, entry_count, status, input ready);
  modport sink   (input valid, selected_index, entry_count, status, output ready);
endinterface

FILE: hdl/wss_scan_unit.sv
module wss_scan_unit (
  input  logic                            clk,
  input  wss_pkg::scan_ctrl_t             ctrl,
  input  logic [wss_pkg::WEIGHT_BITS-1:0] rd_data,
  input  logic [wss_pkg::FRAC_W-1:0]      frac,
  output logic                            total_zero,
  output logic                            hit
);
  import wss_pkg::*;

  logic [SUM_W-1:0]  total_r, total_nxt;
  logic [SUM_W-1:0]  cum_r, cum_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [SUM_W-1:0]  cum_sum;

  assign cum_sum    = cum_r + SUM_W'(rd_data);
  assign hit        = {cum_sum, {FRAC_W{1'b0}}} >= prod_r;
  assign total_zero = (total_r == '0);

  always_comb begin
    total_nxt = total_r;
    cum_nxt   = cum_r;
    prod_nxt  = prod_r;
    if (ctrl.clr) begin
      total_nxt = '0;
      cum_nxt   = '0;
    end else begin
      if (ctrl.add_total) total_nxt = total_r + SUM_W'(rd_data);
      if (ctrl.add_cum)   cum_nxt   = cum_sum;
    end
    if (ctrl.mul) prod_nxt = PROD_W'(frac) * PROD_W'(total_r);
  end

  always_ff @(posedge clk) begin
    total_r <= total_nxt;
    cum_r   <= cum_nxt;
    prod_r  <= prod_nxt;
  end

endmodule

FILE: hdl/weighted_source_selector.sv
// Weighted source selector: a table of up to 16 weights held in a one-port-read,
// one-port-write memory with a registered read. Add, set current weight, choose
// current, clear and every rejected request go from acceptance to the response
// state, which loads the output register once it is free. A sample reads the table
// twice, one entry per cycle through the memory read port: once to total the
// weights, once to walk the running sum against fraction times total up to the
// entry picked; the second pass is skipped when the total is zero. A delete moves
// each later entry down by one through the same read port. One transaction is in
// work at a time; the next is accepted while the previous result still waits in
// the output register.
module weighted_source_selector (
  input  logic      clk,
  input  logic      rst_n,
  wss_in_if.sink    in_ch,
  wss_out_if.source out_ch
);
  import wss_pkg::*;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   cur_r, cur_nxt;
  logic               cur_vld_r, cur_vld_nxt;
  status_t            status_r, status_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [IDX_W-1:0]   out_sel_r, out_sel_nxt;
  logic [CNT_W-1:0]   out_cnt_r, out_cnt_nxt;
  logic [STATUS_W-1:0] out_st_r, out_st_nxt;

  logic [WEIGHT_BITS-1:0] mem [MAX_SOURCES];
  logic [WEIGHT_BITS-1:0] rd_data_r;
  logic                   we;
  logic [IDX_W-1:0]       wa, ra;
  logic [WEIGHT_BITS-1:0] wd;

  scan_ctrl_t scan_ctrl;
  logic       total_zero, hit;
  logic       accept, out_free, reads_left, pass_done;

  assign accept     = in_ch.valid && in_ch.ready;
  assign out_free   = !out_vld_r || out_ch.ready;
  assign reads_left = ptr_r < count_r;
  assign pass_done  = !reads_left && !rd_vld_r;

  wss_scan_unit u_scan (
    .clk        (clk),
    .ctrl       (scan_ctrl),
    .rd_data    (rd_data_r),
    .frac       (frac_r),
    .total_zero (total_zero),
    .hit        (hit)
  );

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data_r <= mem[ra];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.func == FUNC_SAMPLE && count_r != '0) state_nxt = S_SUM;
          else if (in_ch.func == FUNC_DELETE && CNT_W'(in_ch.entry_index) < count_r)
            state_nxt = S_DEL;
          else state_nxt = S_RESP;
        end
      end
      S_SUM:  if (pass_done) state_nxt = S_MUL;
      S_MUL:  state_nxt = total_zero ? S_RESP : S_SCAN;
      S_SCAN: if (rd_vld_r && hit) state_nxt = S_RESP;
      S_DEL:  if (pass_done) state_nxt = S_RESP;
      S_RESP: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready  = (state_r == S_IDLE);
    out_ch.valid = out_vld_r;
    out_ch.selected_index = out_sel_r;
    out_ch.entry_count    = out_cnt_r;
    out_ch.status         = out_st_r;
  end

  always_comb begin
    count_nxt   = count_r;
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    status_nxt  = status_r;
    idx_nxt     = idx_r;
    frac_nxt    = frac_r;
    ptr_nxt     = ptr_r;
    rd_vld_nxt  = 1'b0;
    rd_idx_nxt  = rd_idx_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    out_sel_nxt = out_sel_r;
    out_cnt_nxt = out_cnt_r;
    out_st_nxt  = out_st_r;
    we          = 1'b0;
    wa          = rd_idx_r - IDX_W'(1);
    wd          = rd_data_r;
    ra          = ptr_r[IDX_W-1:0];
    scan_ctrl   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt    = in_ch.entry_index;
          frac_nxt   = in_ch.rand_fraction;
          status_nxt = ST_OK;
          ptr_nxt    = '0;
          scan_ctrl.clr = 1'b1;
          priority case (in_ch.func)
            FUNC_ADD: begin
              if (count_r >= CNT_W'(MAX_SOURCES)) begin
                status_nxt = ST_FULL;
              end else begin
                we          = 1'b1;
                wa          = count_r[IDX_W-1:0];
                wd          = in_ch.weight;
                cur_nxt     = count_r[IDX_W-1:0];
                cur_vld_nxt = 1'b1;
                count_nxt   = count_r + CNT_W'(1);
              end
            end
            FUNC_DELETE: begin
              if (CNT_W'(in_ch.entry_index) >= count_r) status_nxt = ST_BAD_INDEX;
              else ptr_nxt = CNT_W'(in_ch.entry_index) + CNT_W'(1);
            end
            FUNC_SET: begin
              if (!cur_vld_r || CNT_W'(cur_r) >= count_r) begin
                status_nxt = ST_BAD_INDEX;
              end else begin
                we = 1'b1;
                wa = cur_r;
                wd = in_ch.weight;
              end
            end
            FUNC_CHOOSE: begin
              if (CNT_W'(in_ch.entry_index) >= count_r) begin
                status_nxt = ST_BAD_INDEX;
              end else begin
                cur_nxt     = in_ch.entry_index;
                cur_vld_nxt = 1'b1;
              end
            end
            FUNC_CLEAR: begin
              count_nxt   = '0;
              cur_nxt     = '0;
              cur_vld_nxt = 1'b0;
            end
            FUNC_SAMPLE: begin
              if (count_r == '0) status_nxt = ST_EMPTY;
            end
            default: ;
          endcase
        end
      end
      S_SUM: begin
        if (reads_left) begin
          ptr_nxt    = ptr_r + CNT_W'(1);
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = ptr_r[IDX_W-1:0];
        end
        scan_ctrl.add_total = rd_vld_r;
      end
      S_MUL: begin
        scan_ctrl.mul = 1'b1;
        ptr_nxt       = '0;
        if (total_zero) status_nxt = ST_EMPTY;
      end
      S_SCAN: begin
        if (reads_left) begin
          ptr_nxt    = ptr_r + CNT_W'(1);
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = ptr_r[IDX_W-1:0];
        end
        if (rd_vld_r) begin
          scan_ctrl.add_cum = 1'b1;
          if (hit) begin
            cur_nxt     = rd_idx_r;
            cur_vld_nxt = 1'b1;
            rd_vld_nxt  = 1'b0;
          end
        end
      end
      S_DEL: begin
        if (reads_left) begin
          ptr_nxt    = ptr_r + CNT_W'(1);
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = ptr_r[IDX_W-1:0];
        end
        we = rd_vld_r;
        if (pass_done) begin
          count_nxt = count_r - CNT_W'(1);
          if (cur_vld_r && cur_r == idx_r) begin
            cur_nxt     = '0;
            cur_vld_nxt = (count_r > CNT_W'(1));
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          out_sel_nxt = cur_r;
          out_cnt_nxt = count_r;
          out_st_nxt  = status_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      cur_r     <= '0;
      cur_vld_r <= 1'b0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cur_r     <= cur_nxt;
      cur_vld_r <= cur_vld_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    idx_r     <= idx_nxt;
    frac_r    <= frac_nxt;
    ptr_r     <= ptr_nxt;
    rd_idx_r  <= rd_idx_nxt;
    out_sel_r <= out_sel_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_st_r  <= out_st_nxt;
  end

endmodule
